// ===== hdl/msnw_pkg.sv =====
// Shared types, constants and codes of the MIDI stuck note watchdog.
`timescale 1ns / 1ps

package msnw_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 32;
   localparam int TIME_BITS_DEFAULT     = 32;

   localparam int MAX_REPORTS      = 32;
   localparam int REPORT_CNT_BITS  = $clog2(MAX_REPORTS + 1);

   localparam int CH_BITS          = 4;
   localparam int NOTE_BITS        = 7;
   localparam int VEL_BITS         = 7;
   localparam int KEY_BITS         = CH_BITS + NOTE_BITS;
   localparam int MS_BITS          = 32;
   localparam int OP_BITS          = 3;
   localparam int ACTIVE_BITS      = 6;
   localparam int ACTIVE_MAX       = 63;

   localparam int CSR_DATA_BITS    = 32;
   localparam int CSR_INDEX_BITS   = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMEOUT = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHECK   = 1'd1;

   localparam logic [MS_BITS-1:0] TIMEOUT_RESET = 32'd5000;
   localparam logic               CHECK_RESET   = 1'b1;

   localparam logic [OP_BITS-1:0] OP_NOTE_ON  = 3'd0;
   localparam logic [OP_BITS-1:0] OP_NOTE_OFF = 3'd1;
   localparam logic [OP_BITS-1:0] OP_ALL_OFF  = 3'd2;
   localparam logic [OP_BITS-1:0] OP_RESET    = 3'd3;
   localparam logic [OP_BITS-1:0] OP_OTHER    = 3'd4;

   typedef struct packed {
      logic [OP_BITS-1:0]   opcode;
      logic [CH_BITS-1:0]   channel;
      logic [NOTE_BITS-1:0] note_number;
      logic [VEL_BITS-1:0]  velocity;
      logic [MS_BITS-1:0]   now_ms;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]     hung_channel;
      logic [NOTE_BITS-1:0]   hung_note;
      logic [VEL_BITS-1:0]    hung_velocity;
      logic [MS_BITS-1:0]     age_ms;
      logic [ACTIVE_BITS-1:0] active_count;
      logic                   overflowed;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic take;
      logic scan_start;
      logic clear_all;
      logic apply;
      logic report_init;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_update;
      logic is_clear;
      logic check_en;
      logic scan_done;
      logic have_hit;
      logic final_hit;
      logic out_free;
   } ctrl_status_type;

endpackage

// ===== hdl/msnw_ram.sv =====
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module msnw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/msnw_dpath.sv =====
// Datapath: note table, table scans, hung note selection and the result register.
`timescale 1ns / 1ps

module msnw_dpath #(
   parameter int TABLE_ENTRIES = msnw_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int TIME_BITS     = msnw_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  msnw_pkg::req_type                     req_data,
   input  logic                                  csr_wr_en,
   input  logic [msnw_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [msnw_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  msnw_pkg::ctrl_cmd_type                cmd,
   output msnw_pkg::ctrl_status_type             status,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output msnw_pkg::rsp_type                     rsp_data
);

   localparam int IDX_BITS   = $clog2(TABLE_ENTRIES);
   localparam int SCAN_BITS  = IDX_BITS + 1;
   localparam int CNT_BITS   = $clog2(TABLE_ENTRIES + 1);
   localparam int CH_BITS    = msnw_pkg::CH_BITS;
   localparam int NOTE_BITS  = msnw_pkg::NOTE_BITS;
   localparam int VEL_BITS   = msnw_pkg::VEL_BITS;
   localparam int KEY_BITS   = msnw_pkg::KEY_BITS;
   localparam int MS_BITS    = msnw_pkg::MS_BITS;
   localparam int ENTRY_BITS = CH_BITS + NOTE_BITS + VEL_BITS + TIME_BITS;
   localparam int CMP_BITS   = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;
   localparam int RPT_BITS   = msnw_pkg::REPORT_CNT_BITS;

   // Control state.
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic                     overflow_ff, overflow_in;
   logic [MS_BITS-1:0]       timeout_ff, timeout_in;
   logic                     check_ff, check_in;
   logic                     scan_busy_ff, scan_busy_in;
   logic [SCAN_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic                     pend_ff, pend_in;
   logic                     match_found_ff, match_found_in;
   logic                     free_found_ff, free_found_in;
   logic                     have1_ff, have1_in;
   logic                     have2_ff, have2_in;
   logic                     prev_ok_ff, prev_ok_in;
   logic [RPT_BITS-1:0]      reports_ff, reports_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Payload state.
   msnw_pkg::req_type        req_ff, req_in;
   logic [IDX_BITS-1:0]      pend_idx_ff, pend_idx_in;
   logic [IDX_BITS-1:0]      match_idx_ff, match_idx_in;
   logic [IDX_BITS-1:0]      free_idx_ff, free_idx_in;
   logic [KEY_BITS-1:0]      min_key_ff, min_key_in;
   logic [KEY_BITS-1:0]      prev_key_ff, prev_key_in;
   logic [VEL_BITS-1:0]      cap_vel_ff, cap_vel_in;
   logic [MS_BITS-1:0]       cap_age_ff, cap_age_in;
   msnw_pkg::rsp_type        rsp_ff, rsp_in;

   // Table memory.
   logic                     ram_wr_en;
   logic [IDX_BITS-1:0]      ram_wr_addr;
   logic [ENTRY_BITS-1:0]    ram_wr_data;
   logic [ENTRY_BITS-1:0]    ram_rd_data;

   logic [TIME_BITS-1:0]     now_w;
   logic [TIME_BITS-1:0]     rd_start;
   logic [VEL_BITS-1:0]      rd_vel;
   logic [NOTE_BITS-1:0]     rd_note;
   logic [CH_BITS-1:0]       rd_ch;
   logic [KEY_BITS-1:0]      key_w;
   logic [TIME_BITS-1:0]     age_w;
   logic                     ent_valid;
   logic                     hung_w;
   logic                     above_w;
   logic                     is_on;
   logic                     is_off;
   logic                     is_clear;
   logic                     final_w;
   logic                     out_free;
   logic [msnw_pkg::ACTIVE_BITS-1:0] active_w;

   msnw_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (rd_idx_ff[IDX_BITS-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      now_w     = TIME_BITS'(req_ff.now_ms);
      rd_start  = ram_rd_data[TIME_BITS-1:0];
      rd_vel    = ram_rd_data[TIME_BITS +: VEL_BITS];
      rd_note   = ram_rd_data[TIME_BITS + VEL_BITS +: NOTE_BITS];
      rd_ch     = ram_rd_data[TIME_BITS + VEL_BITS + NOTE_BITS +: CH_BITS];
      key_w     = {rd_ch, rd_note};
      age_w     = now_w - rd_start;
      ent_valid = pend_ff && valid_ff[pend_idx_ff];
      hung_w    = ent_valid && (CMP_BITS'(age_w) >= CMP_BITS'(timeout_ff));
      above_w   = !prev_ok_ff || (key_w > prev_key_ff);

      is_on    = (req_ff.opcode == msnw_pkg::OP_NOTE_ON) && (req_ff.velocity != '0);
      is_off   = (req_ff.opcode == msnw_pkg::OP_NOTE_OFF) ||
                 ((req_ff.opcode == msnw_pkg::OP_NOTE_ON) && (req_ff.velocity == '0));
      is_clear = (req_ff.opcode == msnw_pkg::OP_ALL_OFF) ||
                 (req_ff.opcode == msnw_pkg::OP_RESET);

      final_w  = !have2_ff || (reports_ff == RPT_BITS'(msnw_pkg::MAX_REPORTS - 1));
      out_free = !rsp_valid_ff || !rsp_stall;

      if (32'(count_ff) > 32'(msnw_pkg::ACTIVE_MAX)) begin
         active_w = msnw_pkg::ACTIVE_BITS'(msnw_pkg::ACTIVE_MAX);
      end else begin
         active_w = msnw_pkg::ACTIVE_BITS'(count_ff);
      end
   end

   always_comb begin
      valid_in       = valid_ff;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      timeout_in     = timeout_ff;
      check_in       = check_ff;
      scan_busy_in   = scan_busy_ff;
      rd_idx_in      = rd_idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = rd_idx_ff[IDX_BITS-1:0];
      match_found_in = match_found_ff;
      free_found_in  = free_found_ff;
      match_idx_in   = match_idx_ff;
      free_idx_in    = free_idx_ff;
      have1_in       = have1_ff;
      have2_in       = have2_ff;
      min_key_in     = min_key_ff;
      cap_vel_in     = cap_vel_ff;
      cap_age_in     = cap_age_ff;
      prev_ok_in     = prev_ok_ff;
      prev_key_in    = prev_key_ff;
      reports_in     = reports_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      req_in         = req_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = match_idx_ff;
      ram_wr_data    = {req_ff.channel, req_ff.note_number, req_ff.velocity, now_w};

      if (csr_wr_en) begin
         case (csr_index)
            msnw_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            msnw_pkg::CSR_CHECK:   check_in   = csr_wdata[0];
            default: ;
         endcase
      end

      if (cmd.take) begin
         req_in = req_data;
      end

      // Table walk: one read issued per cycle, its data processed in the next cycle.
      if (cmd.scan_start) begin
         scan_busy_in = 1'b1;
         rd_idx_in    = '0;
      end else if (scan_busy_ff) begin
         if (rd_idx_ff < SCAN_BITS'(TABLE_ENTRIES)) begin
            pend_in   = 1'b1;
            rd_idx_in = rd_idx_ff + SCAN_BITS'(1);
         end else begin
            scan_busy_in = 1'b0;
         end
      end

      if (cmd.scan_start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         have1_in       = 1'b0;
         have2_in       = 1'b0;
      end else if (pend_ff) begin
         if (ent_valid && (rd_ch == req_ff.channel) && (rd_note == req_ff.note_number) &&
             !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = pend_idx_ff;
         end
         if (!valid_ff[pend_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = pend_idx_ff;
         end
         // Keep the smallest hung key above the last reported one and note
         // whether a second one exists.
         if (hung_w && above_w) begin
            if (!have1_ff || (key_w < min_key_ff)) begin
               have1_in   = 1'b1;
               have2_in   = have1_ff;
               min_key_in = key_w;
               cap_vel_in = rd_vel;
               cap_age_in = MS_BITS'(age_w);
            end else begin
               have2_in = 1'b1;
            end
         end
      end

      if (cmd.clear_all) begin
         valid_in = '0;
         count_in = '0;
      end

      if (cmd.apply) begin
         if (is_on) begin
            if (match_found_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = match_idx_ff;
            end else if (free_found_ff) begin
               ram_wr_en             = 1'b1;
               ram_wr_addr           = free_idx_ff;
               valid_in[free_idx_ff] = 1'b1;
               count_in              = count_ff + CNT_BITS'(1);
            end else begin
               overflow_in = 1'b1;
            end
         end else if (is_off && match_found_ff) begin
            valid_in[match_idx_ff] = 1'b0;
            count_in               = count_ff - CNT_BITS'(1);
         end
      end

      if (cmd.report_init) begin
         prev_ok_in = 1'b0;
         reports_in = '0;
      end

      if (cmd.emit) begin
         rsp_in.hung_channel  = min_key_ff[KEY_BITS-1 -: CH_BITS];
         rsp_in.hung_note     = min_key_ff[NOTE_BITS-1:0];
         rsp_in.hung_velocity = cap_vel_ff;
         rsp_in.age_ms        = cap_age_ff;
         rsp_in.active_count  = active_w;
         rsp_in.overflowed    = overflow_ff;
         rsp_in.last          = final_w;
         rsp_valid_in         = 1'b1;
         prev_ok_in           = 1'b1;
         prev_key_in          = min_key_ff;
         reports_in           = reports_ff + RPT_BITS'(1);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         timeout_ff     <= msnw_pkg::TIMEOUT_RESET;
         check_ff       <= msnw_pkg::CHECK_RESET;
         scan_busy_ff   <= 1'b0;
         rd_idx_ff      <= '0;
         pend_ff        <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         have1_ff       <= 1'b0;
         have2_ff       <= 1'b0;
         prev_ok_ff     <= 1'b0;
         reports_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         timeout_ff     <= timeout_in;
         check_ff       <= check_in;
         scan_busy_ff   <= scan_busy_in;
         rd_idx_ff      <= rd_idx_in;
         pend_ff        <= pend_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         have1_ff       <= have1_in;
         have2_ff       <= have2_in;
         prev_ok_ff     <= prev_ok_in;
         reports_ff     <= reports_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      pend_idx_ff  <= pend_idx_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      min_key_ff   <= min_key_in;
      prev_key_ff  <= prev_key_in;
      cap_vel_ff   <= cap_vel_in;
      cap_age_ff   <= cap_age_in;
      rsp_ff       <= rsp_in;
   end

   assign status.is_update = is_on || is_off;
   assign status.is_clear  = is_clear;
   assign status.check_en  = check_ff;
   assign status.scan_done = pend_ff && (pend_idx_ff == IDX_BITS'(TABLE_ENTRIES - 1));
   assign status.have_hit  = have1_ff;
   assign status.final_hit = final_w;
   assign status.out_free  = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(valid_ff))
      else $error("active count differs from the number of valid entries");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded while the previous one is still held");

   a_report_limit: assert property (@(posedge clock) disable iff (reset)
      32'(reports_ff) <= msnw_pkg::MAX_REPORTS)
      else $error("more reports than allowed for one message");

endmodule

// ===== hdl/msnw_ctrl.sv =====
// Controller state machine that sequences lookup, update and hung note reporting.
`timescale 1ns / 1ps

module msnw_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  msnw_pkg::ctrl_status_type status,
   output msnw_pkg::ctrl_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_LOOKUP = 3'd2;
   localparam logic [2:0] ST_APPLY  = 3'd3;
   localparam logic [2:0] ST_REPORT = 3'd4;
   localparam logic [2:0] ST_SCAN   = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_update) begin
               cmd.scan_start = 1'b1;
               state_in       = ST_LOOKUP;
            end else begin
               cmd.clear_all = status.is_clear;
               state_in      = ST_REPORT;
            end
         end
         ST_LOOKUP: begin
            if (status.scan_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            if (status.check_en) begin
               cmd.report_init = 1'b1;
               cmd.scan_start  = 1'b1;
               state_in        = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.have_hit) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.final_hit) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_accept_starts_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted transfer did not start decoding");

   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      status.scan_done |-> (state_ff == ST_LOOKUP || state_ff == ST_SCAN))
      else $error("table walk finished outside a scanning state");

endmodule

// ===== hdl/midi_stuck_note_watchdog_unit.sv =====
// Top level of the MIDI stuck note watchdog.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  msnw_pkg::req_type
//   rsp      out        rsp_valid/rsp_stall  msnw_pkg::rsp_type
//   csr      in         csr_wr_en            csr_index, csr_wdata
//
// A note on or note off walks the table once to look up its key and once more before the first
// result; other messages walk it once before the first result. Each further result takes
// another walk of the table memory, which reads one entry per cycle.
// One message is handled at a time; req_stall is high until its last result is loaded.
// Reset clears the table, the overflow flag and the registers to their defaults at once.
// A stalled result holds the controller until the output register is free again.
`timescale 1ns / 1ps

module midi_stuck_note_watchdog_unit #(
   parameter int TABLE_ENTRIES = msnw_pkg::TABLE_ENTRIES_DEFAULT,
   parameter int TIME_BITS     = msnw_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  msnw_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output msnw_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [msnw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [msnw_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   msnw_pkg::ctrl_cmd_type    cmd;
   msnw_pkg::ctrl_status_type status;

   msnw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   msnw_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .TIME_BITS     (TIME_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== test/midi_stuck_note_watchdog_unit_test.sv =====
// Self-checking testbench of the MIDI stuck note watchdog unit.
`timescale 1ns / 1ps

module midi_stuck_note_watchdog_unit_test;
   import msnw_pkg::*;

   localparam int TABLE_DEPTH   = TABLE_ENTRIES_DEFAULT;
   localparam int SETTLE_CYCLES = 150;
   localparam int DRAIN_LIMIT   = 200000;

   typedef struct {
      bit                   used;
      logic [CH_BITS-1:0]   ch;
      logic [NOTE_BITS-1:0] nn;
      logic [VEL_BITS-1:0]  vel;
      logic [MS_BITS-1:0]   start;
   } note_slot_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_data;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_data;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   note_slot_type      note_slots[TABLE_DEPTH];
   bit                 overflow_seen;
   logic [MS_BITS-1:0] timeout_reg;
   bit                 check_on;
   rsp_type            hung_reports_q[$];
   logic [MS_BITS-1:0] stream_ms;
   int                 errors;
   int                 req_idle_pct;
   int                 rsp_stall_pct;
   int                 hold_left;

   midi_stuck_note_watchdog_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic req_type make_msg(logic [OP_BITS-1:0] op, logic [CH_BITS-1:0] ch,
                                        logic [NOTE_BITS-1:0] nn, logic [VEL_BITS-1:0] vel,
                                        logic [MS_BITS-1:0] now);
      req_type m;
      m.opcode      = op;
      m.channel     = ch;
      m.note_number = nn;
      m.velocity    = vel;
      m.now_ms      = now;
      return m;
   endfunction

   function automatic int find_slot(logic [CH_BITS-1:0] ch, logic [NOTE_BITS-1:0] nn);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (note_slots[i].used && note_slots[i].ch == ch && note_slots[i].nn == nn) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void drop_note(logic [CH_BITS-1:0] ch, logic [NOTE_BITS-1:0] nn);
      int idx;
      idx = find_slot(ch, nn);
      if (idx >= 0) begin
         note_slots[idx].used = 1'b0;
      end
   endfunction

   function automatic void predict_hung_reports(req_type m);
      int idx;
      int count;
      int pos;
      int hung_idx[$];
      logic [MS_BITS-1:0] age;
      rsp_type r;
      case (m.opcode)
         OP_NOTE_ON: begin
            if (m.velocity == 0) begin
               drop_note(m.channel, m.note_number);
            end else begin
               idx = find_slot(m.channel, m.note_number);
               if (idx < 0) begin
                  for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                     if (!note_slots[i].used) begin
                        idx = i;
                     end
                  end
               end
               if (idx < 0) begin
                  overflow_seen = 1'b1;
               end else begin
                  note_slots[idx].used  = 1'b1;
                  note_slots[idx].ch    = m.channel;
                  note_slots[idx].nn    = m.note_number;
                  note_slots[idx].vel   = m.velocity;
                  note_slots[idx].start = m.now_ms;
               end
            end
         end
         OP_NOTE_OFF: drop_note(m.channel, m.note_number);
         OP_ALL_OFF, OP_RESET: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               note_slots[i].used = 1'b0;
            end
         end
         default: ;
      endcase
      count = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (note_slots[i].used) begin
            count++;
         end
      end
      if (!check_on) begin
         return;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         age = m.now_ms - note_slots[i].start;
         if (note_slots[i].used && age >= timeout_reg) begin
            pos = hung_idx.size();
            while (pos > 0 && {note_slots[hung_idx[pos-1]].ch, note_slots[hung_idx[pos-1]].nn} >
                              {note_slots[i].ch, note_slots[i].nn}) begin
               pos--;
            end
            hung_idx.insert(pos, i);
         end
      end
      for (int j = 0; j < hung_idx.size() && j < MAX_REPORTS; j++) begin
         idx             = hung_idx[j];
         r.hung_channel  = note_slots[idx].ch;
         r.hung_note     = note_slots[idx].nn;
         r.hung_velocity = note_slots[idx].vel;
         r.age_ms        = m.now_ms - note_slots[idx].start;
         r.active_count  = ACTIVE_BITS'(count);
         r.overflowed    = overflow_seen;
         r.last          = (j == hung_idx.size() - 1 || j == MAX_REPORTS - 1);
         hung_reports_q  = {hung_reports_q, r};
      end
   endfunction

   function automatic bit pick_sounding(output logic [CH_BITS-1:0] ch,
                                        output logic [NOTE_BITS-1:0] nn);
      int used_q[$];
      int idx;
      ch = '0;
      nn = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (note_slots[i].used) begin
            used_q = {used_q, i};
         end
      end
      if (used_q.size() == 0) begin
         return 1'b0;
      end
      idx = used_q[$urandom_range(0, used_q.size() - 1)];
      ch  = note_slots[idx].ch;
      nn  = note_slots[idx].nn;
      return 1'b1;
   endfunction

   function automatic req_type random_msg();
      int pick;
      logic [CH_BITS-1:0] ch;
      logic [NOTE_BITS-1:0] nn;
      req_type m;
      if ($urandom_range(0, 99) < 3) begin
         stream_ms = $urandom();
      end else begin
         stream_ms += $urandom_range(0, 400);
      end
      pick = $urandom_range(0, 99);
      m = make_msg(OP_NOTE_ON, CH_BITS'($urandom_range(0, 15)), NOTE_BITS'($urandom_range(0, 127)),
                   VEL_BITS'($urandom_range(1, 127)), stream_ms);
      if (pick < 45) begin
         if ($urandom_range(0, 19) == 0) begin
            m.velocity = '0;
         end
      end else if (pick < 75 || pick >= 90) begin
         if (pick_sounding(ch, nn)) begin
            m.channel     = ch;
            m.note_number = nn;
         end
         if (pick < 75) begin
            if ($urandom_range(0, 3) == 0) begin
               m.velocity = '0;
            end else begin
               m.opcode = OP_NOTE_OFF;
            end
         end
      end else if (pick < 80) begin
         m.opcode = OP_ALL_OFF;
      end else if (pick < 83) begin
         m.opcode = OP_RESET;
      end else begin
         m.opcode = OP_OTHER + OP_BITS'($urandom_range(0, 3));
      end
      return m;
   endfunction

   task automatic send_msg(req_type m);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_hung_reports(m);
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (hung_reports_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (hung_reports_q.size() != 0) begin
         $error("%0d expected hung-note reports never arrived", hung_reports_q.size());
         errors++;
         hung_reports_q.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_TIMEOUT) begin
         timeout_reg = value;
      end else if (idx == CSR_CHECK) begin
         check_on = value[0];
      end
   endtask

   task automatic run_random(int n);
      repeat (n) send_msg(random_msg());
   endtask

   task automatic test_directed_messages();
      send_msg(make_msg(OP_NOTE_ON, 4'd0, 7'd0, 7'd127, 32'd1000));
      send_msg(make_msg(OP_NOTE_ON, 4'd15, 7'd127, 7'd1, 32'd2000));
      send_msg(make_msg(OP_OTHER, 4'd0, 7'd0, 7'd0, 32'd6000));
      send_msg(make_msg(OP_OTHER + 3'd3, 4'd15, 7'd127, 7'd127, 32'd6999));
      send_msg(make_msg(OP_NOTE_ON, 4'd0, 7'd0, 7'd64, 32'd7000));
      send_msg(make_msg(OP_NOTE_ON, 4'd0, 7'd0, 7'd0, 32'd7100));
      send_msg(make_msg(OP_NOTE_OFF, 4'd15, 7'd127, 7'd33, 32'd7200));
      send_msg(make_msg(OP_NOTE_ON, 4'd3, 7'd60, 7'd100, 32'd8000));
      send_msg(make_msg(OP_NOTE_ON, 4'd3, 7'd61, 7'd90, 32'd8000));
      send_msg(make_msg(OP_ALL_OFF, 4'd9, 7'd60, 7'd0, 32'd20000));
      send_msg(make_msg(OP_NOTE_ON, 4'd5, 7'd5, 7'd5, 32'd20000));
      send_msg(make_msg(OP_RESET, 4'd5, 7'd5, 7'd5, 32'd30000));
      send_msg(make_msg(OP_NOTE_ON, 4'd1, 7'd2, 7'd3, 32'hFFFF_FF00));
      send_msg(make_msg(OP_OTHER, 4'd1, 7'd2, 7'd3, 32'h0000_1400));
      send_msg(make_msg(OP_NOTE_OFF, 4'd1, 7'd2, 7'd0, 32'h0000_1401));
      wait_drained();
      write_csr(CSR_TIMEOUT, 32'd0);
      send_msg(make_msg(OP_NOTE_ON, 4'd7, 7'd70, 7'd7, 32'd123));
      send_msg(make_msg(OP_NOTE_ON, 4'd2, 7'd10, 7'd77, 32'd124));
      wait_drained();
      write_csr(CSR_TIMEOUT, 32'hFFFF_FFFF);
      send_msg(make_msg(OP_NOTE_ON, 4'd4, 7'd4, 7'd44, 32'd1));
      send_msg(make_msg(OP_OTHER, 4'd0, 7'd0, 7'd0, 32'd0));
      wait_drained();
      write_csr(CSR_CHECK, 32'hFFFF_FFFE);
      send_msg(make_msg(OP_OTHER, 4'd0, 7'd0, 7'd0, 32'd0));
      send_msg(make_msg(OP_NOTE_OFF, 4'd4, 7'd4, 7'd0, 32'd2));
      wait_drained();
      write_csr(CSR_CHECK, 32'h8000_0001);
      write_csr(CSR_TIMEOUT, TIMEOUT_RESET);
      send_msg(make_msg(OP_ALL_OFF, 4'd0, 7'd0, 7'd0, 32'd3));
      stream_ms = 32'd3;
   endtask

   task automatic test_table_overflow();
      logic [5:0] i6;
      logic [CH_BITS-1:0] first_ch;
      logic [NOTE_BITS-1:0] first_nn;
      logic [MS_BITS-1:0] base;
      req_type m;
      base = stream_ms;
      for (int i = 0; i < TABLE_DEPTH + 4; i++) begin
         i6 = 6'(i);
         m = make_msg(OP_NOTE_ON, i6[3:0], {i6[5:4], 5'($urandom_range(0, 31))},
                      VEL_BITS'($urandom_range(1, 127)), base + MS_BITS'(i));
         if (i == 0) begin
            first_ch = m.channel;
            first_nn = m.note_number;
         end
         send_msg(m);
      end
      send_msg(make_msg(OP_NOTE_ON, first_ch, first_nn, 7'd9, base + 32'd40));
      send_msg(make_msg(OP_OTHER, 4'd0, 7'd0, 7'd0, base + 32'd6000));
      send_msg(make_msg(OP_NOTE_OFF, first_ch, first_nn, 7'd0, base + 32'd6000));
      send_msg(make_msg(OP_NOTE_ON, 4'd15, 7'd126, 7'd100, base + 32'd6001));
      send_msg(make_msg(OP_RESET, 4'd0, 7'd0, 7'd0, base + 32'd6002));
      stream_ms = base + 32'd6002;
      wait_drained();
   endtask

   task automatic test_idle_phases();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      run_random(28);
      wait_drained();
      write_csr(CSR_TIMEOUT, MS_BITS'($urandom_range(100, 3000)));
      req_idle_pct = 74;
      run_random(28);
      wait_drained();
      write_csr(CSR_TIMEOUT, TIMEOUT_RESET);
      req_idle_pct  = 0;
      rsp_stall_pct = 74;
      run_random(28);
      wait_drained();
      write_csr(CSR_TIMEOUT, MS_BITS'($urandom_range(1000, 20000)));
      req_idle_pct  = 28;
      rsp_stall_pct = 28;
      run_random(28);
      wait_drained();
   endtask

   task automatic test_zero_timeout_traffic();
      write_csr(CSR_TIMEOUT, 32'd0);
      run_random(15);
      wait_drained();
      write_csr(CSR_TIMEOUT, $urandom());
      run_random(10);
      wait_drained();
   endtask

   task automatic test_check_disabled_traffic();
      logic [CSR_DATA_BITS-1:0] value;
      value = $urandom();
      value[0] = 1'b0;
      write_csr(CSR_CHECK, value);
      write_csr(CSR_TIMEOUT, 32'd0);
      run_random(15);
      wait_drained();
      value = $urandom();
      value[0] = 1'b1;
      write_csr(CSR_CHECK, value);
      write_csr(CSR_TIMEOUT, TIMEOUT_RESET);
   endtask

   task automatic test_output_hold_off();
      req_idle_pct  = 0;
      rsp_stall_pct = 28;
      write_csr(CSR_TIMEOUT, 32'd0);
      send_msg(make_msg(OP_NOTE_ON, 4'd6, 7'd66, 7'd66, stream_ms));
      send_msg(make_msg(OP_NOTE_ON, 4'd8, 7'd88, 7'd88, stream_ms));
      hold_left = 3000;
      run_random(12);
      wait_drained();
      write_csr(CSR_TIMEOUT, TIMEOUT_RESET);
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hung_reports_q.size() == 0) begin
            $error("unexpected transfer on rsp: %p", rsp_data);
            errors++;
         end else begin
            want = hung_reports_q.pop_front();
            if (want.hung_channel !== rsp_data.hung_channel) begin
               $error("hung_channel: expected %0d, got %0d", want.hung_channel,
                      rsp_data.hung_channel);
               errors++;
            end
            if (want.hung_note !== rsp_data.hung_note) begin
               $error("hung_note: expected %0d, got %0d", want.hung_note, rsp_data.hung_note);
               errors++;
            end
            if (want.hung_velocity !== rsp_data.hung_velocity) begin
               $error("hung_velocity: expected %0d, got %0d", want.hung_velocity,
                      rsp_data.hung_velocity);
               errors++;
            end
            if (want.age_ms !== rsp_data.age_ms) begin
               $error("age_ms: expected %0d, got %0d", want.age_ms, rsp_data.age_ms);
               errors++;
            end
            if (want.active_count !== rsp_data.active_count) begin
               $error("active_count: expected %0d, got %0d", want.active_count,
                      rsp_data.active_count);
               errors++;
            end
            if (want.overflowed !== rsp_data.overflowed) begin
               $error("overflowed: expected %0d, got %0d", want.overflowed, rsp_data.overflowed);
               errors++;
            end
            if (want.last !== rsp_data.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_wr_en     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      errors        = 0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      hold_left     = 0;
      stream_ms     = '0;
      timeout_reg   = TIMEOUT_RESET;
      check_on      = CHECK_RESET;
      overflow_seen = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         note_slots[i] = '{default: '0};
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_messages();
      wait_drained();
      test_table_overflow();
      test_idle_phases();
      test_zero_timeout_traffic();
      test_check_disabled_traffic();
      test_output_hold_off();
      wait_drained();
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
